>>> hdl/byte_ring_buffer_macros.svh
// Assertion macros used by the checker of the byte ring buffer.
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/brb_pkg.sv
package brb_pkg;

  localparam int DEPTH   = 4096;
  localparam int MAX_RUN = 64;

  // Widths of the count-like fields, of the RAM address and of the run counter.
  localparam int CNT_W  = 13;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_GET   = 2'd1,
    ACT_RESET = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [7:0]         data_byte;
    logic               chunk_first;
    logic [CNT_W-1:0]   count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last;
    logic               accepted;
    logic [CNT_W-1:0]   fill_level;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic cfg_write;
    logic take;
    logic load_resp;
    logic issue_rd;
    logic load_byte;
  } cmd_t;

  typedef struct packed {
    logic gives_result;
    logic starts_run;
    logic run_done;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/brb_ram.sv
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/brb_ctrl.sv
module brb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  brb_pkg::sts_t sts,
  output brb_pkg::cmd_t cmd
);

  brb_pkg::state_t state_r;
  brb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        if (in_valid && !cfg_valid) begin
          if (sts.starts_run) begin
            state_nxt = brb_pkg::ST_READ;
          end else if (sts.gives_result) begin
            state_nxt = brb_pkg::ST_RESP;
          end
        end
      end
      brb_pkg::ST_RESP: begin
        if (sts.out_free) begin
          state_nxt = brb_pkg::ST_IDLE;
        end
      end
      brb_pkg::ST_READ: begin
        state_nxt = brb_pkg::ST_SEND;
      end
      brb_pkg::ST_SEND: begin
        if (sts.out_free) begin
          state_nxt = sts.run_done ? brb_pkg::ST_IDLE : brb_pkg::ST_READ;
        end
      end
      default: state_nxt = brb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        // A capacity write goes first; an input beat waits behind it.
        in_stall      = cfg_valid;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        cmd.take      = in_valid && !cfg_valid;
      end
      brb_pkg::ST_RESP: begin
        cmd.load_resp = sts.out_free;
      end
      brb_pkg::ST_READ: begin
        cmd.issue_rd = 1'b1;
      end
      brb_pkg::ST_SEND: begin
        cmd.load_byte = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> hdl/brb_dp.sv
module brb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  brb_pkg::cmd_t       cmd,
  output brb_pkg::sts_t       sts,
  input  brb_pkg::in_item_t   in_data,
  input  logic [brb_pkg::CNT_W-1:0] cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output brb_pkg::out_item_t  out_data
);

  localparam int CW = brb_pkg::CNT_W;
  localparam int AW = brb_pkg::ADDR_W;
  localparam int RW = brb_pkg::RUN_W;

  logic [CW-1:0] cap_r,     cap_nxt;
  logic [AW-1:0] wpos_r,    wpos_nxt;
  logic [AW-1:0] rpos_r,    rpos_nxt;
  logic [CW-1:0] stored_r,  stored_nxt;
  logic          taking_r,  taking_nxt;
  logic [CW-1:0] remain_r,  remain_nxt;
  logic [RW-1:0] run_r,     run_nxt;
  logic          resp_acc_r, resp_acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  brb_pkg::out_item_t out_r, out_nxt;

  logic [CW-1:0] cap_clamp;
  logic [CW-1:0] free_slots;
  logic          push_ok;
  logic [RW-1:0] req_run;
  logic [RW-1:0] get_n;
  logic [AW-1:0] wpos_adv;
  logic [AW-1:0] rpos_adv;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic          out_free;
  logic          store_now;
  logic [CW-1:0] store_remain;

  brb_ram #(
    .WIDTH (8),
    .DEPTH (brb_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata (in_data.data_byte),
    .re    (ram_re),
    .raddr (rpos_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamp = CW'(1);
    end else if (cfg_data > CW'(brb_pkg::DEPTH)) begin
      cap_clamp = CW'(brb_pkg::DEPTH);
    end else begin
      cap_clamp = cfg_data;
    end
  end

  // Occupancy never exceeds the capacity, so this cannot wrap.
  assign free_slots = cap_r - stored_r;
  assign push_ok    = (in_data.count <= free_slots);

  assign req_run = (in_data.count > CW'(brb_pkg::MAX_RUN)) ? RW'(brb_pkg::MAX_RUN)
                                                           : RW'(in_data.count);
  assign get_n   = (CW'(req_run) > stored_r) ? RW'(stored_r) : req_run;

  assign wpos_adv = ((CW'(wpos_r) + CW'(1)) >= cap_r) ? '0 : wpos_r + AW'(1);
  assign rpos_adv = ((CW'(rpos_r) + CW'(1)) >= cap_r) ? '0 : rpos_r + AW'(1);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.gives_result = 1'b0;
    sts.starts_run   = 1'b0;
    unique case (in_data.action)
      brb_pkg::ACT_PUSH:  sts.gives_result = in_data.chunk_first;
      brb_pkg::ACT_GET: begin
        sts.starts_run   = (get_n != '0);
        sts.gives_result = (get_n == '0);
      end
      brb_pkg::ACT_RESET: sts.gives_result = 1'b1;
      brb_pkg::ACT_NONE:  sts.gives_result = 1'b0;
      default:            sts.gives_result = 1'b0;
    endcase
    sts.run_done = (run_r == '0);
    sts.out_free = out_free;
  end

  // Buffer state.
  always_comb begin
    cap_nxt      = cap_r;
    wpos_nxt     = wpos_r;
    rpos_nxt     = rpos_r;
    stored_nxt   = stored_r;
    taking_nxt   = taking_r;
    remain_nxt   = remain_r;
    run_nxt      = run_r;
    resp_acc_nxt = resp_acc_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    store_now    = 1'b0;
    store_remain = remain_r;

    priority if (cmd.cfg_write) begin
      cap_nxt    = cap_clamp;
      wpos_nxt   = '0;
      rpos_nxt   = '0;
      stored_nxt = '0;
      taking_nxt = 1'b0;
      remain_nxt = '0;
    end else if (cmd.take) begin
      unique case (in_data.action)
        brb_pkg::ACT_PUSH: begin
          if (in_data.chunk_first) begin
            resp_acc_nxt = push_ok;
            taking_nxt   = 1'b0;
            remain_nxt   = '0;
            if (push_ok && (in_data.count != '0)) begin
              store_now    = 1'b1;
              store_remain = in_data.count;
            end
          end else if (taking_r && (remain_r != '0)) begin
            store_now    = 1'b1;
            store_remain = remain_r;
          end
        end
        brb_pkg::ACT_GET: begin
          run_nxt      = get_n;
          resp_acc_nxt = 1'b0;
        end
        brb_pkg::ACT_RESET: begin
          wpos_nxt     = '0;
          rpos_nxt     = '0;
          stored_nxt   = '0;
          taking_nxt   = 1'b0;
          remain_nxt   = '0;
          resp_acc_nxt = 1'b0;
        end
        brb_pkg::ACT_NONE: begin
          resp_acc_nxt = resp_acc_r;
        end
        default: begin
          resp_acc_nxt = resp_acc_r;
        end
      endcase
      if (store_now) begin
        ram_we     = 1'b1;
        wpos_nxt   = wpos_adv;
        stored_nxt = stored_r + CW'(1);
        remain_nxt = store_remain - CW'(1);
        taking_nxt = (store_remain != CW'(1));
      end
    end else if (cmd.issue_rd) begin
      ram_re     = 1'b1;
      rpos_nxt   = rpos_adv;
      stored_nxt = stored_r - CW'(1);
      run_nxt    = run_r - RW'(1);
    end
  end

  // Output register: a loaded beat stays until the far side stops stalling.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_resp) begin
      out_valid_nxt       = 1'b1;
      out_nxt.out_byte    = '0;
      out_nxt.byte_valid  = 1'b0;
      out_nxt.last        = 1'b1;
      out_nxt.accepted    = resp_acc_r;
      out_nxt.fill_level  = stored_r;
    end else if (cmd.load_byte) begin
      out_valid_nxt       = 1'b1;
      out_nxt.out_byte    = ram_rdata;
      out_nxt.byte_valid  = 1'b1;
      out_nxt.last        = (run_r == '0);
      out_nxt.accepted    = 1'b0;
      out_nxt.fill_level  = stored_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CW'(brb_pkg::DEPTH);
      wpos_r      <= '0;
      rpos_r      <= '0;
      stored_r    <= '0;
      taking_r    <= 1'b0;
      remain_r    <= '0;
      run_r       <= '0;
      resp_acc_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      wpos_r      <= wpos_nxt;
      rpos_r      <= rpos_nxt;
      stored_r    <= stored_nxt;
      taking_r    <= taking_nxt;
      remain_r    <= remain_nxt;
      run_r       <= run_nxt;
      resp_acc_r  <= resp_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/byte_ring_buffer.sv
// Circular byte buffer over a 4096-entry single-port-write, single-port-read RAM.
// Push bytes and stray items are taken straight from the idle state. An item that gives a
// single status beat (first byte of a chunk, empty get, reset action) is taken from
// the idle state; it then waits in the response state while a stalled beat fills the
// output register, and then hands its beat over; input is stalled meanwhile. A get of
// n bytes sends them one by one: the read state does the registered RAM read and
// the send state loads the output register. The capacity register is written over
// cfg_valid/cfg_ready while the block is idle and empties the buffer. The RAM is
// not cleared after reset; only written bytes are ever read back.
module byte_ring_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  brb_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output brb_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brb_pkg::CNT_W-1:0]     cfg_data
);

  brb_pkg::cmd_t cmd;
  brb_pkg::sts_t sts;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> hdl/brb_checker.sv
`include "byte_ring_buffer_macros.svh"

module brb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input brb_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input brb_pkg::out_item_t        out_data,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [brb_pkg::CNT_W-1:0] cfg_data
);

  // A stalled beat must stay put.
  `BRB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled beat dropped")
  `BRB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled beat changed")

  // Only byte beats can be other than the last of their run.
  `BRB_ASSERT_NOW(a_status_last, out_valid && !out_data.byte_valid, out_data.last, "status beat not last")

  // A chunk status never carries a byte.
  `BRB_ASSERT_NOW(a_acc_clean, out_valid && out_data.accepted, !out_data.byte_valid && out_data.last && (out_data.out_byte == 8'd0), "accepted beat malformed")

  // The fill level can never pass the number of slots.
  `BRB_ASSERT_NOW(a_fill_range, out_valid, out_data.fill_level <= brb_pkg::CNT_W'(brb_pkg::DEPTH), "fill level out of range")

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);
